/* rtl/core/pwl_pkg.sv */
package pwl_pkg;

	// Table geometry and value format (signed Q16.16).
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;

	// The interpolation factor takes one bit of the slope magnitude per cycle.
	localparam int DIV_STEPS  = VALUE_W;
	localparam int STEP_W     = $clog2(DIV_STEPS + 1);

	// Stream word widths: input words on the slave side, result words on the master side.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 32;

	// Command codes carried in tuser of an input word.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Status codes carried in tuser of a result word.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_NOSEG = 2'd2
	} status_t;

endpackage

/* rtl/core/piecewise_linear_table_interp.sv */
// Channel   Dir  Payload (lowest bit first)                               Handshake
// s_axis    in   tdata: point_index[3:0], x_value[35:4], fx_value[67:36]  tvalid/tready
//                tuser: cmd[0]
// m_axis    out  tdata: result_value[31:0]; tuser: status[1:0]            tvalid/tready
// cfg       in   cfg_wr_data: point_count[4:0]                            cfg_wr_en
//
// A load word is written to the breakpoint memory as soon as it is taken.
// An evaluate word holds off the input until its result is in the output register. An
// empty table goes straight to its result; else a walk over the table, one memory read
// per cycle, checks slot 0 (clamp below, or one point), the last slot (clamp above), then
// each segment in turn; a matching one runs the bit-serial multiply-divide, else no match.
// The result sits in an output register, so a stalled m_axis only holds back the
// next input word once a second result is ready. Reset spares only the memory and its read registers.
module piecewise_linear_table_interp
	import pwl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: point_count.
	input  logic                  cfg_wr_en,
	input  logic [CNT_W-1:0]      cfg_wr_data,
	// Input words.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // point_index, x_value, fx_value, zero pad
	input  logic [0:0]            s_axis_tuser,   // cmd
	// Result words.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // result_value
	output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK0,
		ST_CHKL,
		ST_WALK,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// Breakpoint memory, undefined until written.
	logic signed [VALUE_W-1:0] break_x  [MAX_POINTS];
	logic signed [VALUE_W-1:0] break_fx [MAX_POINTS];
	logic signed [VALUE_W-1:0] rdx_q;
	logic signed [VALUE_W-1:0] rdf_q;
	logic [IDX_W-1:0]          rd_addr;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          n_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [VALUE_W-1:0] x_q;
	logic signed [VALUE_W-1:0] prev_x_q;
	logic signed [VALUE_W-1:0] prev_f_q;
	logic [VALUE_W-1:0]        w_q;
	logic [VALUE_W-1:0]        d_q;
	logic [VALUE_W-1:0]        mag_q;
	logic [VALUE_W-1:0]        rem_q;
	logic [VALUE_W-1:0]        quo_q;
	logic                      neg_q;
	logic [STEP_W-1:0]         step_q;
	logic [VALUE_W-1:0]        res_q;
	status_t                   stat_q;
	logic                      m_valid_q;
	logic [VALUE_W-1:0]        m_data_q;
	status_t                   m_stat_q;

	logic                      in_acc;
	logic [IDX_W-1:0]          in_idx;
	logic signed [VALUE_W-1:0] in_x;
	logic signed [VALUE_W-1:0] in_f;
	logic [CNT_W-1:0]          n_clamp;
	logic [CNT_W-1:0]          n_last;
	logic                      seg_hit;
	logic [VALUE_W:0]          seg_w;
	logic [VALUE_W:0]          seg_d;
	logic signed [VALUE_W:0]   seg_df;
	logic [VALUE_W:0]          seg_mag;
	logic [VALUE_W+1:0]        t_sum;
	logic [VALUE_W+1:0]        w1_ext;
	logic [VALUE_W+1:0]        w2_ext;
	logic [VALUE_W+1:0]        t_red;
	logic [1:0]                q_dig;

	// Input word unpacking.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_idx        = s_axis_tdata[IDX_W-1:0];
	assign in_x          = s_axis_tdata[IDX_W+VALUE_W-1:IDX_W];
	assign in_f          = s_axis_tdata[IDX_W+2*VALUE_W-1:IDX_W+VALUE_W];

	assign n_clamp = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
	assign n_last  = n_q - CNT_W'(1);

	// Read address follows the walk: slot 0, then the last slot, then slots 1, 2, ...
	always_comb begin
		case (state_q)
			ST_CHK0: rd_addr = n_last[IDX_W-1:0];
			ST_CHKL: rd_addr = IDX_W'(1);
			ST_WALK: rd_addr = idx_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	// Memory: written by load words, read with a registered output.
	always_ff @(posedge clk) begin
		if (in_acc && s_axis_tuser[0] == CMD_LOAD) begin
			break_x[in_idx]  <= in_x;
			break_fx[in_idx] <= in_f;
		end
		rdx_q <= break_x[rd_addr];
		rdf_q <= break_fx[rd_addr];
	end

	// Segment test between the previous point and the one just read.
	assign seg_hit = (rdx_q > prev_x_q) && (x_q >= prev_x_q) && (x_q <= rdx_q);
	assign seg_w   = {rdx_q[VALUE_W-1], rdx_q} - {prev_x_q[VALUE_W-1], prev_x_q};
	assign seg_d   = {x_q[VALUE_W-1], x_q} - {prev_x_q[VALUE_W-1], prev_x_q};
	assign seg_df  = {rdf_q[VALUE_W-1], rdf_q} - {prev_f_q[VALUE_W-1], prev_f_q};
	assign seg_mag = seg_df[VALUE_W] ? (VALUE_W+1)'(-seg_df) : seg_df;

	// One multiply-divide step: remainder doubles, takes d if the slope bit is set,
	// then drops zero, one or two widths; the quotient takes that count as its digit.
	assign t_sum  = {1'b0, rem_q, 1'b0} + (mag_q[VALUE_W-1] ? {2'b00, d_q} : '0);
	assign w1_ext = {2'b00, w_q};
	assign w2_ext = {1'b0, w_q, 1'b0};
	always_comb begin
		if (t_sum >= w2_ext) begin
			t_red = t_sum - w2_ext;
			q_dig = 2'd2;
		end else if (t_sum >= w1_ext) begin
			t_red = t_sum - w1_ext;
			q_dig = 2'd1;
		end else begin
			t_red = t_sum;
			q_dig = 2'd0;
		end
	end

	// Control sequence and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			n_q       <= '0;
			idx_q     <= '0;
			x_q       <= '0;
			prev_x_q  <= '0;
			prev_f_q  <= '0;
			w_q       <= '0;
			d_q       <= '0;
			mag_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			neg_q     <= 1'b0;
			step_q    <= '0;
			res_q     <= '0;
			stat_q    <= STATUS_OK;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_stat_q  <= STATUS_OK;
		end else begin
			if (cfg_wr_en) begin
				count_q <= cfg_wr_data;
			end
			// The output register fills from the finished state, else empties on a take.
			if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser[0] == CMD_EVAL) begin
						x_q <= in_x;
						n_q <= n_clamp;
						if (n_clamp == '0) begin
							res_q   <= '0;
							stat_q  <= STATUS_EMPTY;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHK0;
						end
					end
				end
				ST_CHK0: begin
					// Slot 0 is on the read port: clamp below, or single point.
					prev_x_q <= rdx_q;
					prev_f_q <= rdf_q;
					if (x_q < rdx_q || n_q == CNT_W'(1)) begin
						res_q   <= rdf_q;
						stat_q  <= STATUS_OK;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CHKL;
					end
				end
				ST_CHKL: begin
					// Last slot is on the read port: clamp above.
					idx_q <= IDX_W'(1);
					if (x_q > rdx_q) begin
						res_q   <= rdf_q;
						stat_q  <= STATUS_OK;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (seg_hit) begin
						w_q     <= seg_w[VALUE_W-1:0];
						d_q     <= seg_d[VALUE_W-1:0];
						mag_q   <= seg_mag[VALUE_W-1:0];
						neg_q   <= seg_df[VALUE_W];
						rem_q   <= '0;
						quo_q   <= '0;
						step_q  <= STEP_W'(DIV_STEPS);
						state_q <= ST_DIV;
					end else if ({1'b0, idx_q} == n_last) begin
						res_q   <= '0;
						stat_q  <= STATUS_NOSEG;
						state_q <= ST_DONE;
					end else begin
						prev_x_q <= rdx_q;
						prev_f_q <= rdf_q;
						idx_q    <= idx_q + IDX_W'(1);
					end
				end
				ST_DIV: begin
					mag_q  <= {mag_q[VALUE_W-2:0], 1'b0};
					rem_q  <= t_red[VALUE_W-1:0];
					quo_q  <= {quo_q[VALUE_W-2:0], 1'b0} + {{(VALUE_W-2){1'b0}}, q_dig};
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// The sum stays between the two segment end values.
					res_q   <= neg_q ? (prev_f_q - quo_q) : (prev_f_q + quo_q);
					stat_q  <= STATUS_OK;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_data_q  <= res_q;
						m_stat_q  <= stat_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_stat_q;

	// The running remainder always stays below the segment width.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < w_q))
		else $error("multiply-divide remainder reached the segment width");

	// Error results always carry a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
		else $error("error result with a nonzero value");

	// An evaluate word holds off the input for at least the next cycle.
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_EVAL) |=> !s_axis_tready)
		else $error("input taken while an evaluate was in progress");

endmodule
